/* rtl/ws2812se_pkg.sv */
// Package for the WS2812 slice encoder: field widths, frame constants and the
// colour store write-port type. No dependencies.
package ws2812se_pkg;

    localparam int LED_COUNT     = 64;
    localparam int RESET_FRAMES  = 3;
    localparam int SLOT_W        = 7;
    localparam int SLOT_MAX      = LED_COUNT + RESET_FRAMES;

    localparam int STORE_DEPTH   = 64;
    localparam int STORE_AW      = $clog2(STORE_DEPTH);
    localparam int COLOR_W       = 24;
    localparam int BITS_PER_SLOT = COLOR_W;
    localparam int BIT_CNT_W     = $clog2(BITS_PER_SLOT);

    localparam int CFG_W         = 3;
    localparam int LEVELS_W      = 4;

    // Request kinds carried on s_tuser.
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Register value that selects three slices per bit; reset value of the register.
    localparam logic [CFG_W-1:0] SLICES_THREE = 3'd3;
    localparam logic [CFG_W-1:0] SLICES_RESET = 3'd4;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [COLOR_W-1:0]  data;
    } store_wr_t;

endpackage

/* rtl/ws2812_slice_encoder.sv */
// Top level of the WS2812 slice encoder: stream ports, slot counter and the
// bit serializer. Depends on ws2812se_pkg and ws2812se_color_store.

// The block holds one GRB colour per LED (64 entries, reading as zero after
// reset, no clearing pass needed) and a frame-slot counter. An input transfer
// with s_tuser = 1 writes a colour and produces no output; it is accepted at
// any time, also while a slot is being sent. An input transfer with s_tuser = 0
// is a refill tick: it produces 24 output transfers, one per colour bit, green
// MSB first, each giving the line level of every time slice of that bit (high,
// bit, bit, low, or high, bit, low when slices_per_bit is 3). Slots 64 to 67
// are all-low reset slots, after which the counter wraps. A tick occupies the
// bit serializer until its last transfer is taken, one output transfer per
// cycle while m_tready is high, so no new tick is taken while it is busy; the
// next tick is accepted in the cycle the last transfer of the previous one is
// taken. The colour of a slot is read from the store ahead of the tick, so the
// first output transfer of a tick is offered in the cycle right after the tick
// is taken.
module ws2812_slice_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: slices_per_bit.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // led_index[5:0], red[13:6], green[21:14], blue[29:22]
    input  logic [0:0]  s_tuser,   // req_type[0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // slice_levels[3:0], frame_slot[10:4]
    output logic [0:0]  m_tuser,   // is_reset[0]
    output logic        m_tlast    // last bit of the slot
);

    logic [ws2812se_pkg::CFG_W-1:0]     slices_reg;
    logic [ws2812se_pkg::SLOT_W-1:0]    slot_reg;
    logic [ws2812se_pkg::SLOT_W-1:0]    slot_out_reg;
    logic                               rst_out_reg;
    logic                               busy_reg;
    logic [ws2812se_pkg::BIT_CNT_W-1:0] bit_cnt_reg;
    logic [ws2812se_pkg::COLOR_W-1:0]   shift_reg;

    logic                               in_fire;
    logic                               tick_acc;
    logic                               out_fire;
    logic                               out_last;
    logic                               slot_is_reset;
    logic                               cur_bit;
    logic [ws2812se_pkg::LEVELS_W-1:0]  levels;
    logic [ws2812se_pkg::COLOR_W-1:0]   rd_color;
    ws2812se_pkg::store_wr_t            store_wr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slices_reg <= ws2812se_pkg::SLICES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            slices_reg <= cfg_data;
        end
    end

    // Colour writes never wait; a tick waits until the serializer is free or
    // finishes in this very cycle.
    assign out_fire = m_tvalid && m_tready;
    assign out_last = (bit_cnt_reg == ws2812se_pkg::BIT_CNT_W'(ws2812se_pkg::BITS_PER_SLOT - 1));
    assign s_tready = (s_tuser[0] == ws2812se_pkg::REQ_WRITE) || !busy_reg
                      || (m_tready && out_last);
    assign in_fire  = s_tvalid && s_tready;
    assign tick_acc = in_fire && (s_tuser[0] == ws2812se_pkg::REQ_TICK);

    // Store layout is green, red, blue from the top bit down.
    assign store_wr.en   = in_fire && (s_tuser[0] == ws2812se_pkg::REQ_WRITE);
    assign store_wr.addr = s_tdata[5:0];
    assign store_wr.data = {s_tdata[21:14], s_tdata[13:6], s_tdata[29:22]};

    ws2812se_color_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (store_wr),
        .rd_addr (slot_reg[ws2812se_pkg::STORE_AW-1:0]),
        .rd_data (rd_color)
    );

    assign slot_is_reset = (slot_reg >= ws2812se_pkg::SLOT_W'(ws2812se_pkg::LED_COUNT));

    // Slot counter and serializer control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg    <= '0;
            busy_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end else if (tick_acc) begin
            busy_reg    <= 1'b1;
            bit_cnt_reg <= '0;
            if (slot_reg == ws2812se_pkg::SLOT_W'(ws2812se_pkg::SLOT_MAX)) begin
                slot_reg <= '0;
            end else begin
                slot_reg <= slot_reg + 1'b1;
            end
        end else if (out_fire) begin
            if (out_last) begin
                busy_reg <= 1'b0;
            end else begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
        end
    end

    // Serializer payload: the colour shifts out MSB first.
    always_ff @(posedge aclk) begin
        if (tick_acc) begin
            shift_reg    <= slot_is_reset ? '0 : rd_color;
            slot_out_reg <= slot_reg;
            rst_out_reg  <= slot_is_reset;
        end else if (out_fire) begin
            shift_reg <= {shift_reg[ws2812se_pkg::COLOR_W-2:0], 1'b0};
        end
    end

    // Slice 0 is always high, the last slice always low; reset slots stay low.
    assign cur_bit = shift_reg[ws2812se_pkg::COLOR_W-1];
    always_comb begin
        if (rst_out_reg) begin
            levels = '0;
        end else if (slices_reg == ws2812se_pkg::SLICES_THREE) begin
            levels = {1'b0, 1'b0, cur_bit, 1'b1};
        end else begin
            levels = {1'b0, cur_bit, cur_bit, 1'b1};
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = {5'b0, slot_out_reg, levels};
    assign m_tuser  = rst_out_reg;
    assign m_tlast  = out_last;

endmodule

/* rtl/ws2812se_color_store.sv */
// Colour store of the WS2812 slice encoder: one GRB word per LED, read as zero
// until written. Depends on ws2812se_pkg.
module ws2812se_color_store (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ws2812se_pkg::store_wr_t             wr,
    input  logic [ws2812se_pkg::STORE_AW-1:0]   rd_addr,
    output logic [ws2812se_pkg::COLOR_W-1:0]    rd_data
);

    logic [ws2812se_pkg::COLOR_W-1:0]     mem [ws2812se_pkg::STORE_DEPTH];
    logic [ws2812se_pkg::STORE_DEPTH-1:0] valid_reg;
    logic [ws2812se_pkg::COLOR_W-1:0]     mem_q_reg;
    logic [ws2812se_pkg::COLOR_W-1:0]     fwd_data_reg;
    logic                                 fwd_hit_reg;
    logic                                 rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        mem_q_reg    <= mem[rd_addr];
        fwd_data_reg <= wr.data;
    end

    // Valid bits stand in for clearing the array at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            fwd_hit_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            fwd_hit_reg  <= wr.en && (wr.addr == rd_addr);
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // A write to the entry being read shows up in the same read cycle.
    assign rd_data = fwd_hit_reg  ? fwd_data_reg :
                     rd_valid_reg ? mem_q_reg    : '0;

endmodule

/* rtl/ws2812se_checker.sv */
// Port-level checks for the WS2812 slice encoder, bound to its top level.
// Depends on ws2812se_pkg.
module ws2812se_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result holds still.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Reset slots drive the line low in every slice.
    a_reset_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[3:0] == 4'd0)
        else $error("reset slot with a high slice");

    // Data slots always open with a high slice and end low.
    a_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[0] && !m_tdata[3])
        else $error("data bit without high first slice or low last slice");

    // The reset flag follows the slot number.
    a_reset_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[0] == (m_tdata[10:4] >= 7'(ws2812se_pkg::LED_COUNT)))
        else $error("reset flag disagrees with slot");

    // Within a slot the slot number does not change between transfers.
    a_slot_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && $stable(m_tdata[10:4]))
        else $error("slot changed inside a slot");

endmodule

bind ws2812_slice_encoder ws2812se_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/tb_ws2812_slice_encoder.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the WS2812 slice encoder: colour writes, refill
// ticks and slice-mode settings, checked against a built-in predictor.
// Depends on ws2812se_pkg and the ws2812_slice_encoder RTL.

module tb_ws2812_slice_encoder;
    import ws2812se_pkg::*;

    // One input transfer: a refill tick or a colour write.
    typedef struct packed {
        logic                req;
        logic [STORE_AW-1:0] led;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
    } led_req_t;

    // One output transfer: the slice levels of a single colour bit.
    typedef struct packed {
        logic [LEVELS_W-1:0] levels;
        logic [SLOT_W-1:0]   slot;
        logic                is_reset;
        logic                last;
    } slice_word_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;   // led_index[5:0], red[13:6], green[21:14], blue[29:22]
    logic [0:0]        s_tuser   = '0;   // req_type[0]
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;          // slice_levels[3:0], frame_slot[10:4]
    logic [0:0]        m_tuser;          // is_reset[0]
    logic              m_tlast;

    led_req_t          pend_q[$];        // items waiting to be offered
    slice_word_t       bit_words_q[$];   // expected slice words, oldest first
    int                errors = 0;
    int                gen_slot = 0;     // slot the next queued tick will send
    logic              calm = 1'b0;      // no idling on either side when set
    int                hold_req = 0;     // bumped to ask the sink for a long hold-off

    // Predictor state.
    logic [COLOR_W-1:0] color_store [STORE_DEPTH];
    logic [SLOT_W-1:0]  slot_cnt;
    logic [CFG_W-1:0]   slices_cfg;

    always #10 aclk = ~aclk;

    ws2812_slice_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Source side: offers queued items, with random gaps between transfers.
    always @(posedge aclk) begin : drive
        led_req_t item;
        int       gap_left;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pend_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                // This cycle is the first of a gap of random length.
                gap_left = $urandom_range(0, 11);
                s_tvalid <= 1'b0;
            end else begin
                item = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= item.req;
                s_tdata  <= {2'b00, item.blue, item.green, item.red, item.led};
            end
        end
    end

    // Sink side: random stalls, plus one long hold-off on request so that the
    // encoder backs up and stops taking ticks.
    always @(posedge aclk) begin : sink
        int   hold_seen;
        int   hold_left;
        int   stall_left;
        logic ready_nx;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_seen  = 0;
            hold_left  = 0;
            stall_left = 0;
        end else begin
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = 400;
                ready_nx  = 1'b0;
            end else if (hold_left != 0) begin
                hold_left = hold_left - 1;
                ready_nx  = 1'b0;
            end else if (stall_left != 0) begin
                stall_left = stall_left - 1;
                ready_nx   = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 11);
                ready_nx   = 1'b0;
            end else begin
                ready_nx = 1'b1;
            end
            m_tready <= ready_nx;
        end
    end

    // Works out the 24 slice words of the current slot and advances the slot.
    task automatic encode_slot();
        logic                resetting;
        logic [COLOR_W-1:0]  color;
        logic                b;
        slice_word_t         w;
        resetting = (slot_cnt >= LED_COUNT);
        color     = resetting ? '0 : color_store[slot_cnt[STORE_AW-1:0]];
        for (int k = 0; k < BITS_PER_SLOT; k++) begin
            b = color[COLOR_W-1-k];
            if (resetting)
                w.levels = '0;
            else if (slices_cfg == SLICES_THREE)
                w.levels = {2'b00, b, 1'b1};
            else
                w.levels = {1'b0, b, b, 1'b1};
            w.slot     = slot_cnt;
            w.is_reset = resetting;
            w.last     = (k == BITS_PER_SLOT - 1);
            bit_words_q.push_back(w);
        end
        slot_cnt = (slot_cnt == SLOT_MAX) ? '0 : slot_cnt + 1'b1;
    endtask

    task automatic compare_field(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Tracks every accepted transfer in order: the register, the input items
    // that feed the predictor, and the result words that are checked.
    always @(posedge aclk) begin : monitor
        slice_word_t want;
        if (!aresetn) begin
            foreach (color_store[i]) color_store[i] = '0;
            slot_cnt   = '0;
            slices_cfg = SLICES_RESET;
        end else begin
            if (cfg_valid && cfg_ready)
                slices_cfg = cfg_data;
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == REQ_WRITE)
                    color_store[s_tdata[5:0]] = {s_tdata[21:14], s_tdata[13:6],
                                                 s_tdata[29:22]};
                else
                    encode_slot();
            end
            if (m_tvalid && m_tready) begin
                if (bit_words_q.size() == 0) begin
                    $display("%0t ns: result expected none, got levels %h slot %0d",
                             $time, m_tdata[3:0], m_tdata[10:4]);
                    errors++;
                end else begin
                    want = bit_words_q.pop_front();
                    compare_field("slice_levels", 8'(want.levels), 8'(m_tdata[3:0]));
                    compare_field("frame_slot", 8'(want.slot), 8'(m_tdata[10:4]));
                    compare_field("is_reset", 8'(want.is_reset), 8'(m_tuser[0]));
                    compare_field("last", 8'(want.last), 8'(m_tlast));
                end
            end
        end
    end

    task automatic add_tick();
        led_req_t it;
        it       = '0;
        it.req   = REQ_TICK;
        gen_slot = (gen_slot == SLOT_MAX) ? 0 : gen_slot + 1;
        pend_q.push_back(it);
    endtask

    task automatic add_write(input int led, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        led_req_t it;
        it.req   = REQ_WRITE;
        it.led   = STORE_AW'(led);
        it.red   = r;
        it.green = g;
        it.blue  = b;
        pend_q.push_back(it);
    endtask

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly ticks; the rest are writes, aimed either at the slots about to be
    // sent or at arbitrary entries.
    task automatic fill_random(input int count);
        int led;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 55) begin
                add_tick();
            end else begin
                led = gen_slot + $urandom_range(0, 3);
                if (led >= LED_COUNT || $urandom_range(0, 1) == 0)
                    led = $urandom_range(0, STORE_DEPTH - 1);
                add_write(led, rand_level(), rand_level(), rand_level());
            end
        end
    endtask

    // Returns once every item is taken and every expected word has arrived,
    // and then lets a trailing colour write settle. The check is made between
    // edges, when the driver and monitor have settled.
    task automatic wait_idle();
        do @(negedge aclk);
        while (pend_q.size() != 0 || s_tvalid || bit_words_q.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_slices(input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part in the reset four-slice mode.
        add_tick();                           // slot 0 from the cleared store
        add_write(1, 8'hFF, 8'hFF, 8'hFF);
        add_tick();                           // all ones
        add_write(2, 8'h00, 8'hFF, 8'h00);    // green alone shows bit order
        add_write(3, 8'hA5, 8'h5A, 8'hC3);
        add_tick();
        add_tick();
        add_write(63, 8'hFF, 8'h00, 8'hFF);   // top entry
        add_write(0, 8'h01, 8'h80, 8'h7F);    // entry 0, read again after the wrap
        add_tick();                           // slot 4 was never written
        add_write(5, 8'h12, 8'h34, 8'h56);
        add_write(5, 8'h87, 8'h65, 8'h43);    // the second write to an entry wins
        add_tick();
        wait_idle();

        write_slices(SLICES_THREE);
        fill_random(60);
        wait_idle();

        write_slices(3'd7);                   // values other than 3 behave as four slices
        fill_random(60);
        wait_idle();

        write_slices(3'd0);
        fill_random(60);
        wait_idle();

        // The sink holds off for a long stretch while ticks keep coming.
        write_slices(SLICES_THREE);
        fill_random(60);
        hold_req <= hold_req + 1;
        wait_idle();

        // Final part runs at full rate with no idling.
        write_slices(3'd5);
        calm <= 1'b1;
        fill_random(75);
        wait_idle();
        repeat (30) @(posedge aclk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
